// ===== src/sjf_nonpreemptive_scheduler_assert.svh =====
// Assertion macros for the shortest-job-first scheduler checker.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef SJF_NONPREEMPTIVE_SCHEDULER_ASSERT_SVH
`define SJF_NONPREEMPTIVE_SCHEDULER_ASSERT_SVH

// Consequence checked in the same cycle as the antecedent.
`define SJF_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("scheduler assertion failed");

// Consequence checked in the cycle after the antecedent.
`define SJF_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ===== src/sjf_pkg.sv =====
// Shared types and constants of the shortest-job-first scheduler.
// Used by the cells and the top level; depends on nothing.
package sjf_pkg;

  localparam int MAX_JOBS_DEF = 16;
  localparam int DATA_W       = 16;
  localparam int TIME_W       = 21;
  localparam int OUT_IDX_W    = 4;
  // Widths that cover the whole parameter range of MAX_JOBS (up to 64).
  localparam int IDX_MAX_W    = 6;
  localparam int CNT_MAX_W    = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // Running best candidate handed from cell to cell.
  typedef struct packed {
    logic                 found;
    logic [DATA_W-1:0]    best_burst;
    logic [DATA_W-1:0]    best_arr;
    logic [IDX_MAX_W-1:0] best_idx;
    logic                 pend;
    logic [DATA_W-1:0]    next_arr;
  } cand_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                 load;
    logic                 clear;
    logic                 mark;
    logic [IDX_MAX_W-1:0] idx;
    logic [DATA_W-1:0]    arrival;
    logic [DATA_W-1:0]    burst;
    logic [TIME_W-1:0]    cur_time;
    logic [CNT_MAX_W-1:0] job_count;
  } cell_ctl_t;

endpackage

// ===== src/sjf_in_if.sv =====
// Job input channel: valid/ready handshake with one job per beat.
// Depends on nothing.
interface sjf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] arrival_time;
  logic [15:0] burst_length;
  logic        last_job;

  modport source (output valid, output arrival_time, output burst_length,
                  output last_job, input ready);
  modport sink (input valid, input arrival_time, input burst_length,
                input last_job, output ready);
endinterface

// ===== src/sjf_out_if.sv =====
// Result channel: valid/ready handshake with one scheduled job per beat.
// Depends on nothing.
interface sjf_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  job_index;
  logic [20:0] start_tick;
  logic [20:0] finish_tick;
  logic [20:0] wait_ticks;
  logic        last_result;

  modport source (output valid, output job_index, output start_tick,
                  output finish_tick, output wait_ticks, output last_result,
                  input ready);
  modport sink (input valid, input job_index, input start_tick,
                input finish_tick, input wait_ticks, input last_result,
                output ready);
endinterface

// ===== src/sjf_cell.sv =====
// One job slot of the scheduling chain: holds a job and refines the candidate.
// Depends on sjf_pkg.
module sjf_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sjf_pkg::cell_ctl_t ctl,
  input  sjf_pkg::cand_t    cand_in,
  output sjf_pkg::cand_t    cand_out
);

  localparam int IMW = sjf_pkg::IDX_MAX_W;
  localparam int CMW = sjf_pkg::CNT_MAX_W;
  localparam int TW  = sjf_pkg::TIME_W;
  localparam int DW  = sjf_pkg::DATA_W;

  logic [DW-1:0]   arr_r;
  logic [DW-1:0]   burst_r;
  logic            done_r;
  logic            done_nxt;
  logic            hit;
  logic            active;
  sjf_pkg::cand_t  cand_nxt;
  sjf_pkg::cand_t  cand_r;

  assign hit    = (ctl.idx == IMW'(IDX));
  assign active = (CMW'(IDX) < ctl.job_count) && !done_r;

  always_comb begin
    done_nxt = done_r;
    if (ctl.clear) begin
      done_nxt = 1'b0;
    end else if (ctl.load && hit) begin
      done_nxt = 1'b0;
    end else if (ctl.mark && hit) begin
      done_nxt = 1'b1;
    end
  end

  // Strict compares keep the lower index on a tie, as the chain runs upwards.
  always_comb begin
    cand_nxt = cand_in;
    if (active) begin
      if (TW'(arr_r) <= ctl.cur_time) begin
        if (!cand_in.found || (burst_r < cand_in.best_burst)) begin
          cand_nxt.found      = 1'b1;
          cand_nxt.best_burst = burst_r;
          cand_nxt.best_arr   = arr_r;
          cand_nxt.best_idx   = IMW'(IDX);
        end
      end else if (!cand_in.pend || (arr_r < cand_in.next_arr)) begin
        cand_nxt.pend     = 1'b1;
        cand_nxt.next_arr = arr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && hit) begin
      arr_r   <= ctl.arrival;
      burst_r <= ctl.burst;
    end
    cand_r <= cand_nxt;
  end

  assign cand_out = cand_r;

endmodule

// ===== src/sjf_nonpreemptive_scheduler.sv =====
// Non-preemptive shortest-job-first scheduler built as a chain of job cells.
// Idle, it takes jobs back to back; the batch closes on last_job or a full store.
// Per decision the candidate ripples through all MAX_JOBS cells in ST_SCAN;
// ST_DECIDE then makes an idle time jump or, once the output is free, emits a result.
// Reset (rst_n low at a clock edge) empties the batch and clears done flags,
// time and counts; stored arrival and burst values are not cleared.
module sjf_nonpreemptive_scheduler #(
  parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sjf_in_if.sink     in_ch,
  sjf_out_if.source  out_ch
);

  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int SCAN_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int IMW    = sjf_pkg::IDX_MAX_W;
  localparam int CMW    = sjf_pkg::CNT_MAX_W;
  localparam int TW     = sjf_pkg::TIME_W;
  localparam int OIW    = sjf_pkg::OUT_IDX_W;

  sjf_pkg::state_t     state_r, state_nxt;
  logic [SCAN_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic [CNT_W-1:0]    job_count_r, job_count_nxt;
  logic [CNT_W-1:0]    done_count_r, done_count_nxt;
  logic [TW-1:0]       time_r, time_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [OIW-1:0]      out_idx_r, out_idx_nxt;
  logic [TW-1:0]       out_start_r, out_start_nxt;
  logic [TW-1:0]       out_finish_r, out_finish_nxt;
  logic [TW-1:0]       out_wait_r, out_wait_nxt;
  logic                out_last_r, out_last_nxt;

  sjf_pkg::cell_ctl_t  ctl;
  sjf_pkg::cand_t      chain_w [MAX_JOBS+1];
  sjf_pkg::cand_t      res;
  logic [TW-1:0]       finish_w;
  logic                batch_end;

  assign chain_w[0] = '0;
  assign res        = chain_w[MAX_JOBS];

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    sjf_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cand_in  (chain_w[g]),
      .cand_out (chain_w[g+1])
    );
  end

  assign finish_w  = time_r + TW'(res.best_burst);
  assign batch_end = ((done_count_r + CNT_W'(1)) == job_count_r);

  always_comb begin
    state_nxt      = state_r;
    scan_cnt_nxt   = scan_cnt_r;
    job_count_nxt  = job_count_r;
    done_count_nxt = done_count_r;
    time_nxt       = time_r;
    out_valid_nxt  = out_valid_r;
    out_idx_nxt    = out_idx_r;
    out_start_nxt  = out_start_r;
    out_finish_nxt = out_finish_r;
    out_wait_nxt   = out_wait_r;
    out_last_nxt   = out_last_r;
    in_ch.ready    = 1'b0;

    ctl           = '0;
    ctl.idx       = IMW'(job_count_r);
    ctl.arrival   = in_ch.arrival_time;
    ctl.burst     = in_ch.burst_length;
    ctl.cur_time  = time_r;
    ctl.job_count = CMW'(job_count_r);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sjf_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          ctl.load      = 1'b1;
          job_count_nxt = job_count_r + CNT_W'(1);
          if (in_ch.last_job || ((job_count_r + CNT_W'(1)) == CNT_W'(MAX_JOBS))) begin
            state_nxt    = sjf_pkg::ST_SCAN;
            scan_cnt_nxt = '0;
          end
        end
      end
      sjf_pkg::ST_SCAN: begin
        // The chain settles once the candidate has passed every cell.
        scan_cnt_nxt = scan_cnt_r + SCAN_W'(1);
        if (scan_cnt_r == SCAN_W'(MAX_JOBS - 1)) begin
          state_nxt = sjf_pkg::ST_DECIDE;
        end
      end
      sjf_pkg::ST_DECIDE: begin
        if (!res.found) begin
          // Nothing has arrived yet: jump to the earliest pending arrival.
          time_nxt     = TW'(res.next_arr);
          state_nxt    = sjf_pkg::ST_SCAN;
          scan_cnt_nxt = '0;
        end else if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = OIW'(res.best_idx);
          out_start_nxt  = time_r;
          out_finish_nxt = finish_w;
          out_wait_nxt   = time_r - TW'(res.best_arr);
          out_last_nxt   = batch_end;
          ctl.mark       = 1'b1;
          ctl.idx        = res.best_idx;
          if (batch_end) begin
            ctl.clear      = 1'b1;
            job_count_nxt  = '0;
            done_count_nxt = '0;
            time_nxt       = '0;
            state_nxt      = sjf_pkg::ST_IDLE;
          end else begin
            done_count_nxt = done_count_r + CNT_W'(1);
            time_nxt       = finish_w;
            state_nxt      = sjf_pkg::ST_SCAN;
            scan_cnt_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = sjf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sjf_pkg::ST_IDLE;
      scan_cnt_r   <= '0;
      job_count_r  <= '0;
      done_count_r <= '0;
      time_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      job_count_r  <= job_count_nxt;
      done_count_r <= done_count_nxt;
      time_r       <= time_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r    <= out_idx_nxt;
    out_start_r  <= out_start_nxt;
    out_finish_r <= out_finish_nxt;
    out_wait_r   <= out_wait_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.job_index   = out_idx_r;
  assign out_ch.start_tick  = out_start_r;
  assign out_ch.finish_tick = out_finish_r;
  assign out_ch.wait_ticks  = out_wait_r;
  assign out_ch.last_result = out_last_r;

endmodule

// ===== src/sjf_checker.sv =====
// Port-level checks of the scheduler, bound to the top level.
// Depends on sjf_nonpreemptive_scheduler_assert.svh.
`include "sjf_nonpreemptive_scheduler_assert.svh"

module sjf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_job,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_job_index,
  input logic [20:0] out_start_tick,
  input logic [20:0] out_finish_tick,
  input logic [20:0] out_wait_ticks,
  input logic        out_last_result
);

  logic [67:0] out_beat;

  assign out_beat = {out_job_index, out_start_tick, out_finish_tick, out_wait_ticks,
                     out_last_result};

  // A closing beat starts scheduling, so no further job is taken at once.
  `SJF_ASSERT_NEXT(a_close_stops_input, in_valid && in_ready && in_last_job, !in_ready)
  // While a result of an unfinished batch is on offer, the block is still scheduling.
  `SJF_ASSERT_NOW(a_mid_batch_busy, out_valid && !out_last_result, !in_ready)
  `SJF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SJF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_beat))

endmodule

bind sjf_nonpreemptive_scheduler sjf_checker u_sjf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_last_job     (in_ch.last_job),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_job_index   (out_ch.job_index),
  .out_start_tick  (out_ch.start_tick),
  .out_finish_tick (out_ch.finish_tick),
  .out_wait_ticks  (out_ch.wait_ticks),
  .out_last_result (out_ch.last_result)
);

// ===== verif/sjf_nonpreemptive_scheduler_tb.sv =====
// Testbench for the shortest-job-first scheduler: loads job batches and checks each result.
// A run-order predictor is checked against every result beat.
// Depends on sjf_pkg, sjf_in_if, sjf_out_if and sjf_nonpreemptive_scheduler.
`timescale 1ns / 100ps

module sjf_nonpreemptive_scheduler_tb;

  typedef struct packed {
    logic [sjf_pkg::OUT_IDX_W-1:0] idx;
    logic [sjf_pkg::TIME_W-1:0]    start;
    logic [sjf_pkg::TIME_W-1:0]    finish;
    logic [sjf_pkg::TIME_W-1:0]    waited;
    logic                          last;
  } run_t;

  // Holds the batch being loaded and the run order it predicts once the batch closes.
  class sjf_run_order;
    run_t                       expected_runs[$];
    logic [sjf_pkg::DATA_W-1:0] arr_store[sjf_pkg::MAX_JOBS_DEF];
    logic [sjf_pkg::DATA_W-1:0] burst_store[sjf_pkg::MAX_JOBS_DEF];
    int unsigned                loaded;
    int unsigned                mismatches;

    function new();
      loaded     = 0;
      mismatches = 0;
    endfunction

    function void note_job(input logic [sjf_pkg::DATA_W-1:0] arr,
                           input logic [sjf_pkg::DATA_W-1:0] burst, input logic last);
      bit                         done_job[sjf_pkg::MAX_JOBS_DEF];
      int unsigned                completed;
      int unsigned                pick;
      bit                         found;
      bit                         pending;
      logic [sjf_pkg::TIME_W-1:0] now;
      logic [sjf_pkg::TIME_W-1:0] next_arr;
      logic [sjf_pkg::DATA_W-1:0] best;
      run_t                       r;
      arr_store[loaded]   = arr;
      burst_store[loaded] = burst;
      loaded++;
      if (!last && loaded < sjf_pkg::MAX_JOBS_DEF) return;
      now       = '0;
      completed = 0;
      for (int i = 0; i < sjf_pkg::MAX_JOBS_DEF; i++) done_job[i] = 1'b0;
      while (completed < loaded) begin
        found    = 1'b0;
        pending  = 1'b0;
        pick     = 0;
        best     = '0;
        next_arr = '0;
        for (int i = 0; i < loaded; i++) begin
          if (!done_job[i]) begin
            if (sjf_pkg::TIME_W'(arr_store[i]) <= now) begin
              // Strictly smaller only, so ties stay with the lowest index.
              if (!found || burst_store[i] < best) begin
                found = 1'b1;
                best  = burst_store[i];
                pick  = i;
              end
            end else if (!pending || sjf_pkg::TIME_W'(arr_store[i]) < next_arr) begin
              pending  = 1'b1;
              next_arr = sjf_pkg::TIME_W'(arr_store[i]);
            end
          end
        end
        if (!found) begin
          // Nothing has arrived yet, so time jumps to the earliest pending arrival.
          now = next_arr;
        end else begin
          done_job[pick] = 1'b1;
          completed++;
          r.idx    = pick[sjf_pkg::OUT_IDX_W-1:0];
          r.start  = now;
          r.finish = now + sjf_pkg::TIME_W'(burst_store[pick]);
          r.waited = now - sjf_pkg::TIME_W'(arr_store[pick]);
          r.last   = (completed == loaded);
          expected_runs.push_back(r);
          now = r.finish;
        end
      end
      loaded = 0;
    endfunction

    function void check_run(input run_t got);
      run_t want;
      if (expected_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: job %0d start %0d finish %0d wait %0d last %0d",
                   got.idx, got.start, got.finish, got.waited, got.last);
        return;
      end
      want = expected_runs.pop_front();
      if (got.idx !== want.idx || got.start !== want.start || got.finish !== want.finish ||
          got.waited !== want.waited || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected job %0d start %0d finish %0d wait %0d last %0d, %s",
                   want.idx, want.start, want.finish, want.waited, want.last,
                   $sformatf("got job %0d start %0d finish %0d wait %0d last %0d",
                             got.idx, got.start, got.finish, got.waited, got.last));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  logic stall_go     = 1'b0;
  logic stall_on     = 1'b0;

  sjf_run_order run_order;

  sjf_in_if  in_ch ();
  sjf_out_if out_ch ();

  sjf_nonpreemptive_scheduler i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result side: check each accepted beat, then decide next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      run_order.check_run({out_ch.job_index, out_ch.start_tick, out_ch.finish_tick,
                           out_ch.wait_ticks, out_ch.last_result});
    if (!rst_n || stall_on) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Long hold-off of the result side, so the block backs up and refuses new jobs.
  initial begin
    wait (stall_go);
    stall_on <= 1'b1;
    repeat (700) @(posedge clk);
    stall_on <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("sjf_nonpreemptive_scheduler_tb: done, errors");
    $finish;
  end

  task automatic send_job(input logic [15:0] arr, input logic [15:0] burst, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.arrival_time <= arr;
    in_ch.burst_length <= burst;
    in_ch.last_job     <= last;
    do @(posedge clk); while (!in_ch.ready);
    run_order.note_job(arr, burst, last);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (run_order.expected_runs.size() != 0) @(posedge clk);
  endtask

  // Whole batches with random content; about a quarter close by filling the store.
  task automatic run_batches(input int target);
    int          sent;
    int          size;
    int          mode;
    logic [15:0] arr;
    logic [15:0] burst;
    logic        last;
    sent = 0;
    while (sent < target) begin
      size = ($urandom_range(99) < 25) ? sjf_pkg::MAX_JOBS_DEF :
             $urandom_range(sjf_pkg::MAX_JOBS_DEF - 1, 1);
      mode = $urandom_range(3);
      for (int i = 0; i < size; i++) begin
        case (mode)
          0: begin
            arr   = 16'($urandom);
            burst = 16'($urandom);
          end
          1: begin
            arr   = 16'($urandom_range(40));
            burst = 16'($urandom_range(15));
          end
          2: begin
            // Few distinct bursts, so ties between arrived jobs are common.
            arr   = 16'($urandom_range(8));
            burst = 16'(4 * $urandom_range(2));
          end
          default: begin
            // Spread arrivals with short bursts leave the block idle between jobs.
            arr   = 16'($urandom);
            burst = 16'($urandom_range(300));
          end
        endcase
        last = (i == size - 1) && (size < sjf_pkg::MAX_JOBS_DEF || $urandom_range(1) == 1);
        send_job(arr, burst, last);
      end
      sent += size;
    end
  endtask

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.arrival_time <= '0;
    in_ch.burst_length <= '0;
    in_ch.last_job     <= 1'b0;
    rst_n              <= 1'b0;
    run_order = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 27;
    snk_idle_pct = 52;
    send_job(16'h0000, 16'h0000, 1'b1);
    send_job(16'hFFFF, 16'hFFFF, 1'b1);
    // Equal bursts go to the lower index; a shorter late job then goes ahead.
    send_job(16'd0, 16'd4, 1'b0);
    send_job(16'd0, 16'd4, 1'b0);
    send_job(16'd3, 16'd1, 1'b1);
    // Sixteen jobs without the last flag: the full store closes the batch.
    for (int i = 0; i < sjf_pkg::MAX_JOBS_DEF; i++)
      send_job(i[0] ? 16'hAAAA : 16'h5555, i[1] ? 16'hFFFF : 16'h0000, 1'b0);
    run_batches(100);
    wait_drained();

    src_idle_pct = 52;
    snk_idle_pct = 27;
    run_batches(100);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    stall_go <= 1'b1;
    run_batches(110);
    wait_drained();
    repeat (80) @(posedge clk);

    if (run_order.mismatches == 0 && run_order.expected_runs.size() == 0) begin
      $display("sjf_nonpreemptive_scheduler_tb: done, clean");
    end else begin
      $display("sjf_nonpreemptive_scheduler_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/sjf_pkg.sv
src/sjf_in_if.sv
src/sjf_out_if.sv
src/sjf_cell.sv
src/sjf_nonpreemptive_scheduler.sv
src/sjf_checker.sv
verif/sjf_nonpreemptive_scheduler_tb.sv
